[hdl/bws_pkg.sv]
// ----------------------------------------------------------------------------
// bws_pkg
// Shared constants, types and helpers of the bilinear wrap height sampler.
// ----------------------------------------------------------------------------
package bws_pkg;

    localparam int MAX_SIDE        = 256;
    localparam int COORD_FRAC_BITS = 16;

    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int SIDE_W     = SIDE_BITS + 1;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int STORE_SIZE = MAX_SIDE * MAX_SIDE;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_RESET  = 256;
    localparam int COORD_W    = 32;
    localparam int TADDR_W    = 16;
    localparam int TEXEL_W    = 8;
    localparam int HEIGHT_W   = 16;

    localparam int POS_W      = COORD_FRAC_BITS + SIDE_BITS;
    localparam int ROW_W      = TEXEL_W + COORD_FRAC_BITS + 2;
    localparam int COL_W      = ROW_W + COORD_FRAC_BITS + 2;
    localparam int OUT_SHIFT  = 2 * COORD_FRAC_BITS - 8;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef logic [SIDE_W-1:0]          t_side;
    typedef logic [ADDR_BITS-1:0]       t_addr;
    typedef logic [TEXEL_W-1:0]         t_texel;
    typedef logic [COORD_FRAC_BITS-1:0] t_frac;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic en_out;
    } t_pipe_en;

    function automatic t_side clamp_side(input logic [CFG_W-1:0] s);
        if (s < CFG_W'(2)) begin
            clamp_side = SIDE_W'(2);
        end else if (32'(s) > MAX_SIDE) begin
            clamp_side = SIDE_W'(MAX_SIDE);
        end else begin
            clamp_side = SIDE_W'(s);
        end
    endfunction

endpackage

[hdl/bws_if.sv]
// ----------------------------------------------------------------------------
// bws channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bws_in_if;
    import bws_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [TADDR_W-1:0]         texel_address;
    logic [TEXEL_W-1:0]         texel_value;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;

    modport source (
        output valid, action, texel_address, texel_value, coord_u, coord_v,
        input  ready
    );
    modport sink (
        input  valid, action, texel_address, texel_value, coord_u, coord_v,
        output ready
    );
endinterface

interface bws_out_if;
    import bws_pkg::*;

    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] sampled_height;

    modport source (
        output valid, sampled_height,
        input  ready
    );
    modport sink (
        input  valid, sampled_height,
        output ready
    );
endinterface

[hdl/bws_texel_ram.sv]
// ----------------------------------------------------------------------------
// bws_texel_ram
// Texel store copy: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bws_texel_ram (
    input  logic            i_clk,
    input  logic            i_we,
    input  bws_pkg::t_addr  i_waddr,
    input  bws_pkg::t_texel i_wdata,
    input  logic            i_re,
    input  bws_pkg::t_addr  i_raddr_a,
    input  bws_pkg::t_addr  i_raddr_b,
    output bws_pkg::t_texel o_rdata_a,
    output bws_pkg::t_texel o_rdata_b
);
    import bws_pkg::*;

    t_texel mem [STORE_SIZE];
    t_texel r_rdata_a;
    t_texel r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the next stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[hdl/bws_addr_gen.sv]
// ----------------------------------------------------------------------------
// bws_addr_gen
// Scales wrapped coordinate fractions and forms the four texel addresses.
// ----------------------------------------------------------------------------
module bws_addr_gen (
    input  logic                              i_clk,
    input  bws_pkg::t_pipe_en                 i_en,
    input  logic [bws_pkg::TADDR_W-1:0]       i_texel_address,
    input  bws_pkg::t_texel                   i_texel_value,
    input  logic signed [bws_pkg::COORD_W-1:0] i_coord_u,
    input  logic signed [bws_pkg::COORD_W-1:0] i_coord_v,
    input  bws_pkg::t_side                    i_width,
    input  bws_pkg::t_side                    i_height,
    output bws_pkg::t_addr                    o_addr00,
    output bws_pkg::t_addr                    o_addr10,
    output bws_pkg::t_addr                    o_addr01,
    output bws_pkg::t_addr                    o_addr11,
    output bws_pkg::t_frac                    o_tx,
    output bws_pkg::t_frac                    o_ty,
    output bws_pkg::t_addr                    o_wr_addr,
    output bws_pkg::t_texel                   o_wr_data,
    output logic                              o_wr_ok
);
    import bws_pkg::*;

    localparam int PROD_W = SIDE_BITS + SIDE_W;

    logic [SIDE_BITS-1:0] w_m1;
    logic [SIDE_BITS-1:0] h_m1;
    logic [POS_W-1:0]     n_px;
    logic [POS_W-1:0]     n_py;
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic [TADDR_W-1:0]   r_wa1;
    t_texel               r_wd1;

    logic [SIDE_BITS-1:0] x0;
    logic [SIDE_BITS-1:0] x1;
    logic [SIDE_BITS-1:0] y0;
    logic [PROD_W-1:0]    row_prod;
    t_addr                row0;
    t_addr                row1;

    t_addr  r_addr00;
    t_addr  r_addr10;
    t_addr  r_addr01;
    t_addr  r_addr11;
    t_frac  r_tx;
    t_frac  r_ty;
    t_addr  r_wa2;
    t_texel r_wd2;
    logic   r_wr_ok;

    // only the fraction bits matter: the integer part wraps away
    assign w_m1 = SIDE_BITS'(i_width - SIDE_W'(1));
    assign h_m1 = SIDE_BITS'(i_height - SIDE_W'(1));
    assign n_px = POS_W'(i_coord_u[COORD_FRAC_BITS-1:0]) * POS_W'(w_m1);
    assign n_py = POS_W'(i_coord_v[COORD_FRAC_BITS-1:0]) * POS_W'(h_m1);

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_wa1 <= i_texel_address;
            r_wd1 <= i_texel_value;
        end
    end

    // fraction < 1 keeps x0 <= side-2, so the right and lower neighbors never wrap
    assign x0       = r_px[POS_W-1:COORD_FRAC_BITS];
    assign y0       = r_py[POS_W-1:COORD_FRAC_BITS];
    assign x1       = x0 + SIDE_BITS'(1);
    assign row_prod = PROD_W'(y0) * PROD_W'(i_width);
    assign row0     = ADDR_BITS'(row_prod);
    assign row1     = ADDR_BITS'(row_prod + PROD_W'(i_width));

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_addr00 <= row0 + ADDR_BITS'(x0);
            r_addr10 <= row0 + ADDR_BITS'(x1);
            r_addr01 <= row1 + ADDR_BITS'(x0);
            r_addr11 <= row1 + ADDR_BITS'(x1);
            r_tx     <= r_px[COORD_FRAC_BITS-1:0];
            r_ty     <= r_py[COORD_FRAC_BITS-1:0];
            r_wa2    <= ADDR_BITS'(r_wa1);
            r_wd2    <= r_wd1;
            r_wr_ok  <= (32'(r_wa1) < STORE_SIZE);
        end
    end

    assign o_addr00  = r_addr00;
    assign o_addr10  = r_addr10;
    assign o_addr01  = r_addr01;
    assign o_addr11  = r_addr11;
    assign o_tx      = r_tx;
    assign o_ty      = r_ty;
    assign o_wr_addr = r_wa2;
    assign o_wr_data = r_wd2;
    assign o_wr_ok   = r_wr_ok;

endmodule

[hdl/bws_lerp.sv]
// ----------------------------------------------------------------------------
// bws_lerp
// Row lerps along x, then the column lerp along y, truncated to 8.8.
// ----------------------------------------------------------------------------
module bws_lerp (
    input  logic                         i_clk,
    input  bws_pkg::t_pipe_en            i_en,
    input  bws_pkg::t_frac               i_tx,
    input  bws_pkg::t_frac               i_ty,
    input  bws_pkg::t_texel              i_t00,
    input  bws_pkg::t_texel              i_t10,
    input  bws_pkg::t_texel              i_t01,
    input  bws_pkg::t_texel              i_t11,
    output logic [bws_pkg::HEIGHT_W-1:0] o_height
);
    import bws_pkg::*;

    t_frac                   r_tx3;
    t_frac                   r_ty3;
    t_frac                   r_ty4;
    logic signed [ROW_W-1:0] r_a;
    logic signed [ROW_W-1:0] r_b;
    logic [HEIGHT_W-1:0]     r_height;

    logic signed [ROW_W-1:0] t00_w;
    logic signed [ROW_W-1:0] t10_w;
    logic signed [ROW_W-1:0] t01_w;
    logic signed [ROW_W-1:0] t11_w;
    logic signed [ROW_W-1:0] tx_w;
    logic signed [ROW_W-1:0] n_a;
    logic signed [ROW_W-1:0] n_b;

    logic signed [COL_W-1:0] a_w;
    logic signed [COL_W-1:0] diff_w;
    logic signed [COL_W-1:0] ty_w;
    logic signed [COL_W-1:0] col;
    logic [HEIGHT_W-1:0]     n_height;

    // fractions ride along with the texel read
    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_tx3 <= i_tx;
            r_ty3 <= i_ty;
        end
    end

    assign t00_w = ROW_W'($signed({1'b0, i_t00}));
    assign t10_w = ROW_W'($signed({1'b0, i_t10}));
    assign t01_w = ROW_W'($signed({1'b0, i_t01}));
    assign t11_w = ROW_W'($signed({1'b0, i_t11}));
    assign tx_w  = ROW_W'($signed({1'b0, r_tx3}));
    assign n_a   = (t00_w <<< COORD_FRAC_BITS) + (t10_w - t00_w) * tx_w;
    assign n_b   = (t01_w <<< COORD_FRAC_BITS) + (t11_w - t01_w) * tx_w;

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_ty4 <= r_ty3;
        end
    end

    assign a_w    = COL_W'(r_a);
    assign diff_w = COL_W'(r_b - r_a);
    assign ty_w   = COL_W'($signed({1'b0, r_ty4}));
    assign col    = (a_w <<< COORD_FRAC_BITS) + diff_w * ty_w;

    always_comb begin
        if (col < 0) begin
            n_height = '0;
        end else begin
            n_height = col[OUT_SHIFT +: HEIGHT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_out) begin
            r_height <= n_height;
        end
    end

    assign o_height = r_height;

endmodule

[hdl/bilinear_wrap_height_sampler_core.sv]
// ----------------------------------------------------------------------------
// bilinear_wrap_height_sampler_core
// Byte height texture with bilinear, wrap-mode sampling.
// ----------------------------------------------------------------------------
// usage:
//   i_smp carries request words. action 0 stores texel_value at the row-major
//   texel_address and gives no result; action 1 samples at coord_u/coord_v
//   (signed 16.16, fraction only) and gives one word on o_res: the bilinear
//   height as unsigned 8.8, truncated.
//   i_cfg_we/i_cfg_index/i_cfg_data set width (index 0) and height (index 1);
//   sides are clamped to 2..256. write them only while the block is idle.
// timing:
//   one word accepted per cycle, sustained, while o_res is ready. a sample
//   passes the stages scale, address, texel read, row lerp and column lerp
//   on its way to o_res. the texel store sits in two copies, each with two
//   read ports, so all four neighbors are read in the same cycle; writes go
//   to both copies at the read stage, so they stay in order with the samples.
//   if o_res stalls, each pipeline stage keeps accepting until it holds a word;
//   i_smp.ready drops only once every stage is full.
// reset:
//   clears the pipeline valids and sets both sides to 256. texel contents are
//   not cleared and must be written before they are sampled.
// ----------------------------------------------------------------------------
module bilinear_wrap_height_sampler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bws_in_if.sink                        i_smp,
    bws_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [bws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bws_pkg::CFG_W-1:0]     i_cfg_data
);
    import bws_pkg::*;

    logic [CFG_W-1:0] r_width_cfg;
    logic [CFG_W-1:0] r_height_cfg;
    t_side            width;
    t_side            height;

    logic r_v1;
    logic r_s1;
    logic r_v2;
    logic r_s2;
    logic r_v3;
    logic r_v4;
    logic r_out_valid;

    t_pipe_en pe;

    t_addr  addr00;
    t_addr  addr10;
    t_addr  addr01;
    t_addr  addr11;
    t_frac  tx;
    t_frac  ty;
    t_addr  wr_addr;
    t_texel wr_data;
    logic   wr_ok;
    logic   mem_we;
    logic   mem_re;
    t_texel t00;
    t_texel t10;
    t_texel t01;
    t_texel t11;
    logic [HEIGHT_W-1:0] height_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= CFG_W'(CFG_RESET);
            r_height_cfg <= CFG_W'(CFG_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width_cfg  <= i_cfg_data;
                REG_HEIGHT: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign width  = clamp_side(r_width_cfg);
    assign height = clamp_side(r_height_cfg);

    // a stage loads when it is empty or its word moves on
    always_comb begin
        pe.en_out = !r_out_valid || o_res.ready;
        pe.en4    = !r_v4 || pe.en_out;
        pe.en3    = !r_v3 || pe.en4;
        pe.en2    = !r_v2 || pe.en3;
        pe.en1    = !r_v1 || pe.en2;
    end

    assign i_smp.ready = pe.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pe.en1)    r_v1        <= i_smp.valid;
            if (pe.en2)    r_v2        <= r_v1;
            if (pe.en3)    r_v3        <= r_v2 && (r_s2 == ACT_SAMPLE);
            if (pe.en4)    r_v4        <= r_v3;
            if (pe.en_out) r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pe.en1) r_s1 <= i_smp.action;
        if (pe.en2) r_s2 <= r_s1;
    end

    assign mem_we = pe.en3 && r_v2 && (r_s2 == ACT_WRITE) && wr_ok;
    assign mem_re = pe.en3 && r_v2 && (r_s2 == ACT_SAMPLE);

    bws_addr_gen u_addr_gen (
        .i_clk           (i_clk),
        .i_en            (pe),
        .i_texel_address (i_smp.texel_address),
        .i_texel_value   (i_smp.texel_value),
        .i_coord_u       (i_smp.coord_u),
        .i_coord_v       (i_smp.coord_v),
        .i_width         (width),
        .i_height        (height),
        .o_addr00        (addr00),
        .o_addr10        (addr10),
        .o_addr01        (addr01),
        .o_addr11        (addr11),
        .o_tx            (tx),
        .o_ty            (ty),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_wr_ok         (wr_ok)
    );

    // copy for the upper row of the footprint
    bws_texel_ram u_ram_row0 (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_re      (mem_re),
        .i_raddr_a (addr00),
        .i_raddr_b (addr10),
        .o_rdata_a (t00),
        .o_rdata_b (t10)
    );

    // copy for the lower row of the footprint
    bws_texel_ram u_ram_row1 (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_re      (mem_re),
        .i_raddr_a (addr01),
        .i_raddr_b (addr11),
        .o_rdata_a (t01),
        .o_rdata_b (t11)
    );

    bws_lerp u_lerp (
        .i_clk    (i_clk),
        .i_en     (pe),
        .i_tx     (tx),
        .i_ty     (ty),
        .i_t00    (t00),
        .i_t10    (t10),
        .i_t01    (t01),
        .i_t11    (t11),
        .o_height (height_q)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.sampled_height = height_q;

    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("texel store written and read by one word");

    a_sample_reaches_lerp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> r_v3)
        else $error("sample read issued but texel stage empty");

    a_stall_holds_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready && r_v4) |=> r_v4)
        else $error("row lerp stage lost a word under stall");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pe.en3 && r_v2 && (r_s2 == ACT_WRITE)) |=> !r_v3)
        else $error("write word produced a texel stage entry");

endmodule
